>>> hdl/ubx_frame_parser_top_defines.svh
// ----------------------------------------------------------------------------
// ubx frame parser assertion macros
// shared concurrent assertion forms, clocked on aclk, off during reset
// ----------------------------------------------------------------------------
`ifndef UBX_FRAME_PARSER_TOP_DEFINES_SVH
`define UBX_FRAME_PARSER_TOP_DEFINES_SVH

// same-cycle implication
`define UFP_ASSERT_IMP(name, cond, expr, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (expr)) \
        else $error(msg);

// next-cycle implication
`define UFP_ASSERT_NXT(name, cond, expr, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (expr)) \
        else $error(msg);

`endif

>>> hdl/ufp_pkg.sv
// ----------------------------------------------------------------------------
// ufp_pkg
// types and constants for the ubx frame parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ufp_pkg;

    // ubx sync pair
    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;

    // apb register map: one 32-bit register per word
    localparam int          CFG_ADDR_W         = 3;
    localparam int          CFG_DATA_W         = 32;
    localparam logic        CFG_IDX_ACCEPT_BAD = 1'b0;

    // parse phase
    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_SYNC2   = 3'd1,
        PH_CLASS   = 3'd2,
        PH_ID      = 3'd3,
        PH_LEN1    = 3'd4,
        PH_LEN2    = 3'd5,
        PH_PAYLOAD = 3'd6,
        PH_CKB     = 3'd7
    } phase_t;

endpackage

>>> hdl/ubx_frame_parser_top.sv
// ----------------------------------------------------------------------------
// ubx_frame_parser_top
// frames ubx messages from a byte stream, runs the 8-bit fletcher check and
// reports per byte whether it belongs to a frame and how the frame ended
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake                 payload
//   s_        in         s_valid / s_ready         s_rx_byte
//   m_        out        m_valid / m_ready         flags, class, id, length
//   apb       in         psel/penable/pwrite/pready accept_bad_checksum
//
// one item per cycle sustained while m_ready stays high; an item lands in the
// input register, then the parser state and the result register update together,
// so a result reaches the output through the input register and the result register
// aresetn is synchronous, active low; it clears the parse state, the sums,
// the stored class/id/length and the bad-checksum override
// a stalled result holds in the result register while one more item waits
// in the input register; s_ready drops only when both are full
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "ubx_frame_parser_top_defines.svh"

module ubx_frame_parser_top
    import ufp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    // byte input
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_rx_byte,

    // per-byte result
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_byte_in_frame,
    output logic                  m_frame_end,
    output logic                  m_frame_accepted,
    output logic                  m_checksum_ok,
    output logic [7:0]            m_msg_class,
    output logic [7:0]            m_msg_id,
    output logic [15:0]           m_payload_len,
    output logic                  m_payload_byte,

    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    // ------------------------------------------------------------------
    // configuration register
    // ------------------------------------------------------------------
    logic accept_bad_reg;
    logic cfg_hit;

    // register index is the word address bit; byte lanes ignored
    assign cfg_hit = (paddr[CFG_ADDR_W-1] == CFG_IDX_ACCEPT_BAD);
    assign pready  = 1'b1;
    assign prdata  = cfg_hit ? {{(CFG_DATA_W-1){1'b0}}, accept_bad_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accept_bad_reg <= 1'b0;
        end else if (psel && penable && pwrite && pready && cfg_hit) begin
            accept_bad_reg <= pwdata[0];
        end
    end

    // ------------------------------------------------------------------
    // input register
    // ------------------------------------------------------------------
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_free;
    logic       advance;

    // result register can load when empty or being drained this cycle
    assign out_free = !m_valid || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    // ------------------------------------------------------------------
    // parser state
    // ------------------------------------------------------------------
    phase_t      phase_reg,        phase_next;
    logic [7:0]  sum_a_reg,        sum_a_next;
    logic [7:0]  sum_b_reg,        sum_b_next;
    logic [15:0] bytes_left_reg,   bytes_left_next;
    logic [15:0] class_id_reg,     class_id_next;
    logic [15:0] length_seen_reg,  length_seen_next;
    logic [7:0]  check_a_reg,      check_a_next;

    logic        byte_in_frame_next;
    logic        frame_end_next;
    logic        checksum_ok_next;
    logic        payload_byte_next;
    logic        left_zero;
    logic [7:0]  sum_a_add;

    assign left_zero = (bytes_left_reg == 16'd0);
    // running fletcher step shared by id, length and payload bytes
    assign sum_a_add = sum_a_reg + in_byte_reg;

    // next phase
    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_HUNT, PH_SYNC2: begin
                // a wrong second sync byte is looked at again as a first one
                if (phase_reg == PH_SYNC2 && in_byte_reg == SYNC_SECOND) begin
                    phase_next = PH_CLASS;
                end else if (in_byte_reg == SYNC_FIRST) begin
                    phase_next = PH_SYNC2;
                end else begin
                    phase_next = PH_HUNT;
                end
            end
            PH_CLASS:   phase_next = PH_ID;
            PH_ID:      phase_next = PH_LEN1;
            PH_LEN1:    phase_next = PH_LEN2;
            PH_LEN2:    phase_next = PH_PAYLOAD;
            // payload phase also takes ck_a once the count runs out
            PH_PAYLOAD: phase_next = left_zero ? PH_CKB : PH_PAYLOAD;
            PH_CKB:     phase_next = PH_HUNT;
        endcase
    end

    // datapath and result fields
    always_comb begin
        sum_a_next         = sum_a_reg;
        sum_b_next         = sum_b_reg;
        bytes_left_next    = bytes_left_reg;
        class_id_next      = class_id_reg;
        length_seen_next   = length_seen_reg;
        check_a_next       = check_a_reg;
        byte_in_frame_next = 1'b1;
        frame_end_next     = 1'b0;
        checksum_ok_next   = 1'b0;
        payload_byte_next  = 1'b0;
        unique case (phase_reg)
            PH_HUNT, PH_SYNC2: begin
                byte_in_frame_next = (phase_reg == PH_SYNC2 && in_byte_reg == SYNC_SECOND)
                                     || (in_byte_reg == SYNC_FIRST);
            end
            PH_CLASS: begin
                sum_a_next    = in_byte_reg;
                sum_b_next    = in_byte_reg;
                class_id_next = {in_byte_reg, 8'h00};
            end
            PH_ID: begin
                sum_a_next    = sum_a_add;
                sum_b_next    = sum_b_reg + sum_a_add;
                class_id_next = {class_id_reg[15:8], in_byte_reg};
            end
            PH_LEN1: begin
                sum_a_next       = sum_a_add;
                sum_b_next       = sum_b_reg + sum_a_add;
                bytes_left_next  = {8'h00, in_byte_reg};
                length_seen_next = {8'h00, in_byte_reg};
            end
            PH_LEN2: begin
                sum_a_next       = sum_a_add;
                sum_b_next       = sum_b_reg + sum_a_add;
                bytes_left_next  = {in_byte_reg, bytes_left_reg[7:0]};
                length_seen_next = {in_byte_reg, bytes_left_reg[7:0]};
            end
            PH_PAYLOAD: begin
                if (!left_zero) begin
                    bytes_left_next   = bytes_left_reg - 16'd1;
                    sum_a_next        = sum_a_add;
                    sum_b_next        = sum_b_reg + sum_a_add;
                    payload_byte_next = 1'b1;
                end else begin
                    check_a_next = in_byte_reg;
                end
            end
            PH_CKB: begin
                frame_end_next   = 1'b1;
                checksum_ok_next = (check_a_reg == sum_a_reg) && (in_byte_reg == sum_b_reg);
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_HUNT;
            sum_a_reg       <= 8'h00;
            sum_b_reg       <= 8'h00;
            bytes_left_reg  <= 16'h0000;
            class_id_reg    <= 16'h0000;
            length_seen_reg <= 16'h0000;
            check_a_reg     <= 8'h00;
        end else if (advance) begin
            phase_reg       <= phase_next;
            sum_a_reg       <= sum_a_next;
            sum_b_reg       <= sum_b_next;
            bytes_left_reg  <= bytes_left_next;
            class_id_reg    <= class_id_next;
            length_seen_reg <= length_seen_next;
            check_a_reg     <= check_a_next;
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    logic        m_valid_reg;
    logic        byte_in_frame_reg;
    logic        frame_end_reg;
    logic        frame_accepted_reg;
    logic        checksum_ok_reg;
    logic [15:0] res_class_id_reg;
    logic [15:0] res_len_reg;
    logic        payload_byte_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            byte_in_frame_reg  <= byte_in_frame_next;
            frame_end_reg      <= frame_end_next;
            frame_accepted_reg <= frame_end_next && (checksum_ok_next || accept_bad_reg);
            checksum_ok_reg    <= checksum_ok_next;
            res_class_id_reg   <= class_id_next;
            res_len_reg        <= length_seen_next;
            payload_byte_reg   <= payload_byte_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_byte_in_frame  = byte_in_frame_reg;
    assign m_frame_end      = frame_end_reg;
    assign m_frame_accepted = frame_accepted_reg;
    assign m_checksum_ok    = checksum_ok_reg;
    assign m_msg_class      = res_class_id_reg[15:8];
    assign m_msg_id         = res_class_id_reg[7:0];
    assign m_payload_len    = res_len_reg;
    assign m_payload_byte   = payload_byte_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `UFP_ASSERT_IMP(a_end_flags, m_valid && (m_checksum_ok || m_frame_accepted),
                    m_frame_end, "check flags outside frame end")
    `UFP_ASSERT_NXT(a_ckb_to_hunt, advance && phase_reg == PH_CKB,
                    phase_reg == PH_HUNT, "no return to hunt after frame end")
    `UFP_ASSERT_NXT(a_payload_count, advance && phase_reg == PH_PAYLOAD && !left_zero,
                    bytes_left_reg == $past(bytes_left_reg) - 16'd1,
                    "payload count did not step")
    `UFP_ASSERT_NXT(a_item_held, in_valid_reg && !advance,
                    in_valid_reg && $stable(in_byte_reg), "waiting item lost")

endmodule
